/* src/fdtns_pkg.sv */
// Shared constants, types and codes for the device-tree node name search.
`timescale 1ns / 1ps

package fdtns_pkg;

	// Longest name prefix compared, and width of the word counters
	localparam int MAX_NAME_BYTES = 16;
	localparam int INDEX_BITS     = 30;

	// Fixed field widths
	localparam int WORD_BITS   = 32;
	localparam int TARGET_BITS = 64;
	localparam int LEN_BITS    = 5;
	localparam int POS_BITS    = 5;
	localparam int TGT_BYTES   = 16;
	localparam int CFG_IDX_BITS = 2;

	// Structure block tokens
	localparam logic [WORD_BITS-1:0] TAG_BEGIN   = 32'd1;
	localparam logic [WORD_BITS-1:0] TAG_ENDNODE = 32'd2;
	localparam logic [WORD_BITS-1:0] TAG_PROP    = 32'd3;
	localparam logic [WORD_BITS-1:0] TAG_NOP     = 32'd4;
	localparam logic [WORD_BITS-1:0] TAG_END     = 32'd9;

	// Configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_STRUCT_OFFSET = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_TARGET_HEAD   = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_TARGET_TAIL   = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_TARGET_LENGTH = 2'd3;

	// Walk phase
	typedef enum logic [2:0] {
		PH_TOKEN = 3'd0,
		PH_NAME  = 3'd1,
		PH_PLEN  = 3'd2,
		PH_POFF  = 3'd3,
		PH_PSKIP = 3'd4
	} phase_t;

	// Result of comparing one name word
	typedef struct packed {
		logic                hit;
		logic                still_equal;
		logic [POS_BITS-1:0] name_pos;
		logic                name_end;
	} name_cmp_t;

endpackage

/* src/fdtns_name_cmp.sv */
// Compare the four bytes of one node name word against the target prefix.
`timescale 1ns / 1ps

module fdtns_name_cmp
	import fdtns_pkg::*;
(
	input  logic [WORD_BITS-1:0]   word,
	input  logic                   still_equal,
	input  logic [POS_BITS-1:0]    name_pos,
	input  logic [LEN_BITS-1:0]    len,
	input  logic [TARGET_BITS-1:0] target_head,
	input  logic [TARGET_BITS-1:0] target_tail,
	output name_cmp_t              res
);

	logic [7:0] tgt [TGT_BYTES];

	// Split the target into bytes, first byte in the top bits of head
	always_comb begin
		for (int k = 0; k < TGT_BYTES; k++) begin
			if (k < 8) begin
				tgt[k] = target_head[TARGET_BITS-1-8*k -: 8];
			end else begin
				tgt[k] = target_tail[TARGET_BITS-1-8*(k-8) -: 8];
			end
		end
	end

	// Walk the bytes in stream order; stop at a hit or the terminating zero
	always_comb begin
		logic                done;
		logic                hit;
		logic                se;
		logic                nend;
		logic [POS_BITS-1:0] pos;
		logic [7:0]          nb;
		logic [7:0]          tb;
		done = 1'b0;
		hit  = 1'b0;
		se   = still_equal;
		nend = 1'b0;
		pos  = name_pos;
		nb   = '0;
		tb   = '0;
		for (int b = 0; b < 4; b++) begin
			if (!done) begin
				nb = word[WORD_BITS-1-8*b -: 8];
				if (se && (pos < len)) begin
					tb = tgt[pos[3:0]];
					if (nb != tb) begin
						se = 1'b0;
					end else if (nb == 8'd0) begin
						hit = 1'b1;
					end else begin
						pos = pos + 1'b1;
						if (pos == len) begin
							hit = 1'b1;
						end
					end
				end
				if (nb == 8'd0) begin
					nend = 1'b1;
				end
				if (hit || (nb == 8'd0)) begin
					done = 1'b1;
				end
			end
		end
		res.hit         = hit;
		res.still_equal = se;
		res.name_pos    = pos;
		res.name_end    = nend;
	end

endmodule

/* src/fdt_node_name_search.sv */
// Top level of the device-tree node name search: walks structure words, reports the match.
`timescale 1ns / 1ps
//
//  channel   signals                                    direction
//  -------   ----------------------------------------   ---------
//  in        in_valid, in_ready, word, first            request in
//  out       out_valid, out_ready, found, match_offset  result out
//  cfg       cfg_valid, cfg_ready, cfg_index, cfg_data  register write
//
//  One word per cycle while the result is not stalled: a word is held in the
//  input register, where the tag decode and four-byte name compare update the
//  walk state and, on a match or an end tag, load the result register.
//  Reset leaves the block idle until a word marked first arrives.
//  A stalled result holds the input register, which then holds in_ready low.

module fdt_node_name_search
	import fdtns_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [WORD_BITS-1:0]    word,
	input  logic                    first,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    found,
	output logic [WORD_BITS-1:0]    match_offset,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [TARGET_BITS-1:0]  cfg_data
);

	localparam logic [INDEX_BITS-1:0] IDX_MAX = {INDEX_BITS{1'b1}};
	localparam logic [LEN_BITS-1:0]   LEN_MAX = LEN_BITS'(MAX_NAME_BYTES);

	// Configuration registers
	logic [WORD_BITS-1:0]   struct_offset_q;
	logic [TARGET_BITS-1:0] target_head_q;
	logic [TARGET_BITS-1:0] target_tail_q;
	logic [LEN_BITS-1:0]    target_length_q;

	// Input register
	logic                 valid_s1;
	logic [WORD_BITS-1:0] word_s1;
	logic                 first_s1;

	// Walk state
	phase_t                phase_q, phase_d;
	logic [INDEX_BITS-1:0] word_index_q, word_index_d;
	logic [INDEX_BITS-1:0] skip_left_q, skip_left_d;
	logic [POS_BITS-1:0]   name_pos_q, name_pos_d;
	logic                  still_equal_q, still_equal_d;
	logic [WORD_BITS-1:0]  node_start_q, node_start_d;
	logic                  finished_q, finished_d;

	// Result register
	logic                 out_valid_q;
	logic                 found_q;
	logic [WORD_BITS-1:0] match_offset_q;

	logic                 fire;
	logic                 res_load;
	logic                 res_found;
	logic [WORD_BITS-1:0] res_offset;
	logic [LEN_BITS-1:0]  len;
	logic [POS_BITS-1:0]  cmp_pos;
	logic                 cmp_se;
	name_cmp_t            cmp;

	assign fire      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || fire;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign match_offset = match_offset_q;

	assign len = (target_length_q > LEN_MAX) ? LEN_MAX : target_length_q;

	// A first word restarts the name compare as well
	assign cmp_pos = first_s1 ? '0 : name_pos_q;
	assign cmp_se  = first_s1 ? 1'b1 : still_equal_q;

	fdtns_name_cmp u_name_cmp (
		.word        (word_s1),
		.still_equal (cmp_se),
		.name_pos    (cmp_pos),
		.len         (len),
		.target_head (target_head_q),
		.target_tail (target_tail_q),
		.res         (cmp)
	);

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			struct_offset_q <= '0;
			target_head_q   <= '0;
			target_tail_q   <= '0;
			target_length_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_STRUCT_OFFSET: struct_offset_q <= cfg_data[WORD_BITS-1:0];
				REG_TARGET_HEAD:   target_head_q   <= cfg_data;
				REG_TARGET_TAIL:   target_tail_q   <= cfg_data;
				REG_TARGET_LENGTH: target_length_q <= cfg_data[LEN_BITS-1:0];
				default:           ;
			endcase
		end
	end

	// Capture the request into the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			word_s1  <= word;
			first_s1 <= first;
		end
	end

	// Decode the token and advance the walk
	always_comb begin
		phase_t                ph;
		logic [INDEX_BITS-1:0] wi;
		logic [INDEX_BITS-1:0] sk;
		logic [WORD_BITS:0]    plen_sum;
		logic [WORD_BITS-2:0]  plen_words;
		logic                  fin;
		logic                  hit;
		logic                  tag_end;

		ph  = first_s1 ? PH_TOKEN : phase_q;
		wi  = first_s1 ? '0 : word_index_q;
		sk  = first_s1 ? '0 : skip_left_q;
		fin = first_s1 ? 1'b0 : finished_q;
		hit = 1'b0;
		tag_end = 1'b0;
		plen_sum   = '0;
		plen_words = '0;

		phase_d       = ph;
		word_index_d  = wi;
		skip_left_d   = sk;
		name_pos_d    = cmp_pos;
		still_equal_d = cmp_se;
		node_start_d  = node_start_q;
		finished_d    = fin;

		if (!fin) begin
			unique case (ph)
				PH_TOKEN: begin
					if (word_s1 == TAG_BEGIN) begin
						node_start_d  = struct_offset_q + (WORD_BITS'(wi) << 2);
						name_pos_d    = '0;
						still_equal_d = 1'b1;
						phase_d       = PH_NAME;
						hit           = (len == '0);
					end else if (word_s1 == TAG_PROP) begin
						phase_d = PH_PLEN;
					end else if (word_s1 == TAG_END) begin
						tag_end = 1'b1;
					end
				end
				PH_NAME: begin
					name_pos_d    = cmp.name_pos;
					still_equal_d = cmp.still_equal;
					hit           = cmp.hit;
					if (cmp.name_end) begin
						phase_d = PH_TOKEN;
					end
				end
				PH_PLEN: begin
					// Round the value length up to words, saturate at the counter
					plen_sum   = {1'b0, word_s1} + (WORD_BITS+1)'(3);
					plen_words = plen_sum[WORD_BITS:2];
					if (plen_words > (WORD_BITS-1)'(IDX_MAX)) begin
						skip_left_d = IDX_MAX;
					end else begin
						skip_left_d = plen_words[INDEX_BITS-1:0];
					end
					phase_d = PH_POFF;
				end
				PH_POFF: begin
					phase_d = (sk == '0) ? PH_TOKEN : PH_PSKIP;
				end
				default: begin
					// Skip property value words
					if (sk != '0) begin
						skip_left_d = sk - 1'b1;
					end
					if (skip_left_d == '0) begin
						phase_d = PH_TOKEN;
					end
				end
			endcase

			word_index_d = wi + 1'b1;

			if (hit || tag_end) begin
				finished_d = 1'b1;
				phase_d    = PH_TOKEN;
			end
		end

		res_load   = fire && !fin && (hit || tag_end);
		res_found  = hit;
		res_offset = hit ? node_start_d : '0;
	end

	// Hold walk state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_TOKEN;
			word_index_q  <= '0;
			skip_left_q   <= '0;
			name_pos_q    <= '0;
			still_equal_q <= 1'b1;
			node_start_q  <= '0;
			finished_q    <= 1'b1;
		end else if (fire) begin
			phase_q       <= phase_d;
			word_index_q  <= word_index_d;
			skip_left_q   <= skip_left_d;
			name_pos_q    <= name_pos_d;
			still_equal_q <= still_equal_d;
			node_start_q  <= node_start_d;
			finished_q    <= finished_d;
		end
	end

	// Load or drop the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			found_q        <= res_found;
			match_offset_q <= res_offset;
		end
	end

endmodule

/* verif/tb_fdt_node_name_search.sv */
// Testbench for the device-tree node name search: directed token cases, then random structure blocks.
`timescale 1ns / 1ps

module tb_fdt_node_name_search;
	import fdtns_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_WORDS = 1350;
	localparam int WALK_PHASES  = 6;
	localparam int DRAIN_CYCLES = 6;
	localparam logic [INDEX_BITS-1:0] SKIP_CEIL = '1;

	logic                    clk;
	logic                    arst_n      = 1'b0;
	logic                    in_valid    = 1'b0;
	logic                    in_ready;
	logic [WORD_BITS-1:0]    word        = '0;
	logic                    first       = 1'b0;
	logic                    out_valid;
	logic                    out_ready   = 1'b0;
	logic                    found;
	logic [WORD_BITS-1:0]    match_offset;
	logic                    cfg_valid   = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index   = '0;
	logic [TARGET_BITS-1:0]  cfg_data    = '0;

	typedef struct packed {
		logic                 found;
		logic [WORD_BITS-1:0] offset;
	} match_t;

	// Matches predicted but not yet seen at the output
	match_t pending_matches[$];

	// Predicted register contents
	logic [WORD_BITS-1:0]   p_offset;
	logic [TARGET_BITS-1:0] p_head;
	logic [TARGET_BITS-1:0] p_tail;
	logic [LEN_BITS-1:0]    p_len;

	// Predicted walk state
	phase_t                p_phase;
	logic [INDEX_BITS-1:0] p_index;
	logic [INDEX_BITS-1:0] p_skip;
	logic [POS_BITS-1:0]   p_pos;
	logic                  p_equal;
	logic [WORD_BITS-1:0]  p_start;
	logic                  p_done;

	// Words of the structure block being built
	logic [WORD_BITS-1:0] block_words[$];

	int mismatch_count = 0;
	int sent_words     = 0;
	int cycle_count    = 0;
	int rx_wait        = 0;
	bit tx_calm        = 1'b0;
	bit rx_calm        = 1'b0;

	fdt_node_name_search dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.word        (word),
		.first       (first),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.found       (found),
		.match_offset(match_offset),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("fdt_node_name_search verification failed");
			$finish;
		end
	end

	// Target byte at a name position, first byte in the top bits
	function automatic logic [7:0] target_byte(input logic [POS_BITS-1:0] p);
		logic [TARGET_BITS-1:0] src;
		src = (p < 8) ? p_head : p_tail;
		return src[63 - 8 * p[2:0] -: 8];
	endfunction

	// Advance the predicted walk by one word; return 1 when it yields a result
	function automatic logic walk_word(input logic [WORD_BITS-1:0] w, input logic f,
			output match_t m);
		logic                hit;
		logic                fin;
		logic                stop;
		logic [LEN_BITS-1:0] lim;
		logic [7:0]          nb;
		logic [32:0]         words;
		int                  b;
		hit  = 1'b0;
		fin  = 1'b0;
		stop = 1'b0;
		m    = '0;
		lim  = (p_len > MAX_NAME_BYTES) ? LEN_BITS'(MAX_NAME_BYTES) : p_len;
		if (f) begin
			p_done  = 1'b0;
			p_phase = PH_TOKEN;
			p_index = '0;
			p_skip  = '0;
			p_pos   = '0;
			p_equal = 1'b1;
		end
		if (p_done)
			return 1'b0;
		case (p_phase)
			PH_TOKEN: begin
				if (w == TAG_BEGIN) begin
					p_start = p_offset + {p_index, 2'b00};
					p_pos   = '0;
					p_equal = 1'b1;
					p_phase = PH_NAME;
					if (lim == 0)
						hit = 1'b1;
				end else if (w == TAG_PROP) begin
					p_phase = PH_PLEN;
				end else if (w == TAG_END) begin
					fin = 1'b1;
				end
			end
			PH_NAME: begin
				// Compare bytes until a hit or the terminating zero
				for (b = 0; b < 4; b++) begin
					if (!hit && !stop) begin
						nb = w[31 - 8 * b -: 8];
						if (p_equal && p_pos < lim) begin
							if (nb != target_byte(p_pos)) begin
								p_equal = 1'b0;
							end else if (nb == 8'h00) begin
								hit = 1'b1;
							end else begin
								p_pos = p_pos + 1'b1;
								if (p_pos == lim)
									hit = 1'b1;
							end
						end
						if (nb == 8'h00) begin
							p_phase = PH_TOKEN;
							stop    = 1'b1;
						end
					end
				end
			end
			PH_PLEN: begin
				// Round the value length up to words, saturating the count
				words   = ({1'b0, w} + 33'd3) >> 2;
				p_skip  = (words > SKIP_CEIL) ? SKIP_CEIL : words[INDEX_BITS-1:0];
				p_phase = PH_POFF;
			end
			PH_POFF: begin
				p_phase = (p_skip == 0) ? PH_TOKEN : PH_PSKIP;
			end
			default: begin
				if (p_skip != 0)
					p_skip = p_skip - 1'b1;
				if (p_skip == 0)
					p_phase = PH_TOKEN;
			end
		endcase
		p_index = p_index + 1'b1;
		if (hit) begin
			p_done   = 1'b1;
			p_phase  = PH_TOKEN;
			m.found  = 1'b1;
			m.offset = p_start;
			return 1'b1;
		end
		if (fin) begin
			p_done = 1'b1;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Check each accepted result and draw the next stall
	always @(posedge clk) begin
		match_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_matches.size() == 0) begin
				$display("%0t: result with none pending: found=%0b match_offset=%h",
					$time, found, match_offset);
				mismatch_count++;
			end else begin
				want = pending_matches.pop_front();
				if (found !== want.found) begin
					$display("%0t: found expected %0b actual %0b", $time, want.found, found);
					mismatch_count++;
				end
				if (match_offset !== want.offset) begin
					$display("%0t: match_offset expected %h actual %h",
						$time, want.offset, match_offset);
					mismatch_count++;
				end
			end
			rx_wait = rx_calm ? 0 : $urandom_range(0, 8);
		end
		if (rx_wait != 0) begin
			out_ready <= 1'b0;
			rx_wait--;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Send one word after a random gap and predict its outcome
	task automatic send_word(input logic [WORD_BITS-1:0] w, input logic f);
		int     gap;
		match_t m;
		gap = tx_calm ? 0 : $urandom_range(0, 8);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		word     <= w;
		first    <= f;
		do @(posedge clk); while (!in_ready);
		sent_words++;
		if (walk_word(w, f, m))
			pending_matches.push_back(m);
	endtask

	// Drop valid, wait out every pending match and the pipeline
	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_matches.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write all four registers, junk in the unused data bits
	task automatic write_config(input logic [WORD_BITS-1:0] off,
			input logic [TARGET_BITS-1:0] head, input logic [TARGET_BITS-1:0] tail,
			input logic [LEN_BITS-1:0] len);
		logic [TARGET_BITS-1:0]  data [4];
		logic [CFG_IDX_BITS-1:0] regs [4];
		int                      i;
		regs[0] = REG_STRUCT_OFFSET;
		regs[1] = REG_TARGET_HEAD;
		regs[2] = REG_TARGET_TAIL;
		regs[3] = REG_TARGET_LENGTH;
		data[0] = {32'($urandom()), off};
		data[1] = head;
		data[2] = tail;
		data[3] = {32'($urandom()), 27'($urandom()), len};
		for (i = 0; i < 4; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= regs[i];
			cfg_data  <= data[i];
			do @(posedge clk); while (!cfg_ready);
			case (regs[i])
				REG_STRUCT_OFFSET: p_offset = data[i][WORD_BITS-1:0];
				REG_TARGET_HEAD:   p_head   = data[i];
				REG_TARGET_TAIL:   p_tail   = data[i];
				default:           p_len    = data[i][LEN_BITS-1:0];
			endcase
		end
		cfg_valid <= 1'b0;
	endtask

	// Mostly a small alphabet so names often share target bytes
	function automatic logic [7:0] name_char();
		if ($urandom_range(0, 3) == 0)
			return 8'($urandom_range(1, 255));
		return 8'($urandom_range(8'h61, 8'h64));
	endfunction

	task automatic pick_target(output logic [TARGET_BITS-1:0] head,
			output logic [TARGET_BITS-1:0] tail);
		logic [7:0] tb [16];
		int         n;
		int         style;
		int         i;
		n     = $urandom_range(0, 16);
		style = $urandom_range(0, 5);
		for (i = 0; i < 16; i++) begin
			if (style == 0)
				tb[i] = 8'($urandom());
			else if (i < n)
				tb[i] = name_char();
			else
				tb[i] = 8'h00;
		end
		for (i = 0; i < 8; i++) begin
			head[63 - 8 * i -: 8] = tb[i];
			tail[63 - 8 * i -: 8] = tb[8 + i];
		end
	endtask

	// Append a padded node name, often sharing a prefix with the target
	task automatic push_name();
		logic [7:0] nm [$];
		int         k;
		int         extra;
		int         mode;
		int         i;
		mode = $urandom_range(0, 3);
		k    = (mode < 2) ? $urandom_range(0, 16) : 0;
		for (i = 0; i < k && target_byte(POS_BITS'(i)) != 8'h00; i++)
			nm.push_back(target_byte(POS_BITS'(i)));
		extra = (mode == 1) ? 0 : $urandom_range(0, 6);
		repeat (extra) nm.push_back(name_char());
		nm.push_back(8'h00);
		// Pad to a whole word, sometimes with junk after the zero
		while (nm.size() % 4 != 0)
			nm.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'h00);
		for (i = 0; i < nm.size(); i += 4)
			block_words.push_back({nm[i], nm[i+1], nm[i+2], nm[i+3]});
	endtask

	task automatic push_prop();
		logic [WORD_BITS-1:0] len;
		len = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
		block_words.push_back(TAG_PROP);
		block_words.push_back(len);
		block_words.push_back($urandom());
		repeat ((len + 3) / 4) block_words.push_back($urandom());
	endtask

	// Build a well-formed structure block with random content
	task automatic build_tree();
		int depth;
		int act;
		block_words.delete();
		if ($urandom_range(0, 3) == 0)
			block_words.push_back(TAG_NOP);
		block_words.push_back(TAG_BEGIN);
		push_name();
		depth = 1;
		repeat ($urandom_range(2, 12)) begin
			act = $urandom_range(0, 9);
			if (act < 4) begin
				push_prop();
			end else if (act < 7) begin
				block_words.push_back(TAG_BEGIN);
				push_name();
				depth++;
			end else if (act < 9 && depth > 1) begin
				block_words.push_back(TAG_ENDNODE);
				depth--;
			end else if (act < 9) begin
				block_words.push_back(TAG_NOP);
			end else begin
				// Unknown tag, skipped as one word
				block_words.push_back(($urandom_range(0, 2) == 0) ? 32'd0 :
					32'($urandom_range(5, 8)));
			end
		end
		repeat (depth) block_words.push_back(TAG_ENDNODE);
		block_words.push_back(TAG_END);
	endtask

	task automatic send_block(input int cut);
		int i;
		for (i = 0; i < cut; i++)
			send_word(block_words[i], i == 0);
	endtask

	// Random tokens, restarts now and then
	task automatic send_noise();
		int                   n;
		int                   i;
		logic [WORD_BITS-1:0] w;
		n = $urandom_range(3, 16);
		for (i = 0; i < n; i++) begin
			case ($urandom_range(0, 4))
				0:       w = $urandom();
				1:       w = 32'($urandom_range(0, 10));
				2:       w = TAG_PROP;
				3:       w = TAG_BEGIN;
				default: w = {24'($urandom()), 8'h00};
			endcase
			send_word(w, i == 0 || $urandom_range(0, 15) == 0);
		end
	endtask

	// Words after reset without a first mark are ignored
	task automatic test_idle_after_reset();
		send_word(TAG_END, 1'b0);
		send_word(TAG_BEGIN, 1'b0);
	endtask

	// Zero length hits at the begin tag; the offset wraps to zero
	task automatic test_zero_length_wrap();
		drain_results();
		write_config(32'hFFFF_FFFC, '0, '0, 5'd0);
		send_word(TAG_NOP, 1'b1);
		send_word(TAG_BEGIN, 1'b0);
	endtask

	// Skip a mismatched node, a property and an unknown tag, then match a short target
	task automatic test_name_match();
		drain_results();
		write_config(32'h0000_0038, {"cpu@0", 24'h0}, '0, 5'd16);
		send_word(TAG_BEGIN, 1'b1);
		send_word({"cpx", 8'h00}, 1'b0);
		send_word(TAG_PROP, 1'b0);
		send_word(32'd5, 1'b0);
		send_word(32'h0000_000C, 1'b0);
		send_word("abcd", 1'b0);
		send_word({"e", 24'h0}, 1'b0);
		send_word(TAG_ENDNODE, 1'b0);
		send_word(32'd7, 1'b0);
		send_word(TAG_BEGIN, 1'b0);
		send_word("cpu@", 1'b0);
		send_word({"0", 24'h0}, 1'b0);
	endtask

	task automatic test_end_token();
		send_word(TAG_END, 1'b1);
	endtask

	// Length above the limit compares all sixteen bytes
	task automatic test_long_target();
		drain_results();
		write_config(32'h0, "abcdefgh", "ijklmnop", 5'd31);
		send_word(TAG_BEGIN, 1'b1);
		send_word("abcd", 1'b0);
		send_word("efgh", 1'b0);
		send_word("ijkl", 1'b0);
		send_word("mnop", 1'b0);
	endtask

	// Largest property length, then restart mid-skip
	task automatic test_huge_property();
		send_word(TAG_PROP, 1'b1);
		send_word(32'hFFFF_FFFF, 1'b0);
		send_word(32'h0, 1'b0);
		send_word(32'hFFFF_FFFF, 1'b0);
		send_word(TAG_END, 1'b1);
	endtask

	// Random blocks over several register settings
	task automatic test_random_walks();
		int                     phase_no;
		int                     goal;
		int                     kind;
		logic [WORD_BITS-1:0]   off;
		logic [TARGET_BITS-1:0] head;
		logic [TARGET_BITS-1:0] tail;
		logic [LEN_BITS-1:0]    len;
		for (phase_no = 0; phase_no < WALK_PHASES; phase_no++) begin
			drain_results();
			pick_target(head, tail);
			case (phase_no)
				0:       begin off = 32'hFFFF_FFFF; len = 5'd31; end
				1:       begin off = 32'h0;         len = 5'd0;  end
				2:       begin off = $urandom();    len = 5'd16; end
				default: begin off = $urandom();    len = 5'($urandom_range(1, 20)); end
			endcase
			tx_calm = (phase_no == 2);
			rx_calm = (phase_no == 3);
			write_config(off, head, tail, len);
			goal = sent_words + RANDOM_WORDS / WALK_PHASES;
			while (sent_words < goal) begin
				// Hold off now and then until every match is out
				if ($urandom_range(0, 11) == 0)
					drain_results();
				kind = $urandom_range(0, 9);
				if (kind == 0) begin
					send_noise();
				end else begin
					build_tree();
					send_block((kind == 1) ? $urandom_range(1, block_words.size()) :
						block_words.size());
				end
			end
		end
		tx_calm = 1'b0;
		rx_calm = 1'b0;
	endtask

	initial begin
		p_offset = '0;
		p_head   = '0;
		p_tail   = '0;
		p_len    = '0;
		p_phase  = PH_TOKEN;
		p_index  = '0;
		p_skip   = '0;
		p_pos    = '0;
		p_equal  = 1'b1;
		p_start  = '0;
		p_done   = 1'b1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_idle_after_reset();
		test_zero_length_wrap();
		test_name_match();
		test_end_token();
		test_long_target();
		test_huge_property();
		test_random_walks();
		drain_results();
		if (mismatch_count == 0)
			$display("fdt_node_name_search verification clean");
		else
			$display("fdt_node_name_search verification failed");
		$finish;
	end

endmodule
